// ===== hdl/ambient_light_lux_calculator_top_assert.svh =====
// assertion macros used by the lux calculator module alc_lux_calc
`ifndef AMBIENT_LIGHT_LUX_CALCULATOR_TOP_ASSERT_SVH
`define AMBIENT_LIGHT_LUX_CALCULATOR_TOP_ASSERT_SVH

// implication checked every clock outside reset
`define ALC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ALC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/alc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_pkg
// constants, types and coefficient tables of the lux calculator
// ----------------------------------------------------------------------------
package alc_pkg;

    localparam int CH_W    = 25;   // scaled channel width (16 + 9 bits)
    localparam int RQ_W    = 11;   // quotient bits of the ratio division
    localparam int NCELL   = RQ_W; // one division cell per quotient bit
    localparam int COEF_W  = 10;
    localparam int PROD_W  = CH_W + COEF_W;
    localparam int VAL_W   = PROD_W + 17;

    localparam logic [15:0] SCALE_T0 = 16'h7517;
    localparam logic [15:0] SCALE_T1 = 16'h0fe7;
    localparam logic [15:0] SCALE_NONE = 16'h0400;

    // register indexes
    localparam logic [1:0] REG_CALIB   = 2'd0;
    localparam logic [1:0] REG_GAIN    = 2'd1;
    localparam logic [1:0] REG_INTEG   = 2'd2;
    localparam logic [1:0] REG_PACKAGE = 2'd3;

    localparam logic [1:0] INTEG_13MS  = 2'd0;
    localparam logic [1:0] INTEG_101MS = 2'd1;

    // per-word payload carried along the cell row
    typedef struct packed {
        logic [CH_W-1:0]  ch0;
        logic [CH_W-1:0]  ch1;
        logic             kind;
        logic [16:0]      factor;
    } alc_item_t;

    typedef struct packed {
        logic [CH_W+RQ_W-1:0] rem;   // partial remainder, wide enough for shifts
        logic [RQ_W-1:0]      quo;
    } alc_div_t;

    typedef struct packed {
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] m;
    } alc_coef_t;

    // segment lookup on the rounded q9 ratio
    function automatic alc_coef_t seg_lookup(input logic kind, input logic [RQ_W-1:0] r);
        alc_coef_t c;
        c = '0;
        if (!kind) begin
            if (r <= 11'h0b3)      c = '{10'h1f4, 10'h2a4};
            else if (r <= 11'h100) c = '{10'h217, 10'h30a};
            else if (r <= 11'h133) c = '{10'h1da, 10'h28f};
            else if (r <= 11'h171) c = '{10'h177, 10'h1ec};
            else if (r <= 11'h1b3) c = '{10'h08d, 10'h0a6};
        end else begin
            if (r <= 11'h0b3)      c = '{10'h1d3, 10'h27f};
            else if (r <= 11'h0e6) c = '{10'h214, 10'h333};
            else if (r <= 11'h10a) c = '{10'h265, 10'h3e5};
            else if (r <= 11'h157) c = '{10'h102, 10'h13c};
            else if (r <= 11'h1b3) c = '{10'h0dd, 10'h104};
        end
        return c;
    endfunction

endpackage

// ===== hdl/alc_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_div_cell
// one restoring-division cell: settles one quotient bit and hands on
// ----------------------------------------------------------------------------
module alc_div_cell #(
    parameter int BIT = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 stall,
    input  logic                 in_valid,
    input  alc_pkg::alc_item_t   in_item,
    input  alc_pkg::alc_div_t    in_div,
    output logic                 out_valid,
    output alc_pkg::alc_item_t   out_item,
    output alc_pkg::alc_div_t    out_div
);
    localparam int DW = alc_pkg::CH_W + alc_pkg::RQ_W;

    logic               valid_reg;
    alc_pkg::alc_item_t item_reg;
    alc_pkg::alc_div_t  div_reg, div_next;
    logic [DW-1:0]      dshift;

    // trial subtract of divisor shifted to this bit
    always_comb begin
        dshift   = DW'(in_item.ch0) << BIT;
        div_next = in_div;
        if (in_item.ch0 != '0 && in_div.rem >= dshift) begin
            div_next.rem      = in_div.rem - dshift;
            div_next.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!stall) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            item_reg <= in_item;
            div_reg  <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_div   = div_reg;
endmodule

// ===== hdl/alc_lux_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_lux_calc
// coefficient lookup, products, calibration multiply and saturation
// ----------------------------------------------------------------------------
`include "ambient_light_lux_calculator_top_assert.svh"
module alc_lux_calc (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 stall,
    input  logic                 in_valid,
    input  alc_pkg::alc_item_t   in_item,
    input  logic [alc_pkg::RQ_W-1:0] in_quo,
    output logic                 out_valid,
    output logic [31:0]          lux,
    output logic                 sat
);
    localparam int PW = alc_pkg::PROD_W;
    localparam int VW = alc_pkg::VAL_W;

    logic [alc_pkg::RQ_W-1:0] ratio;
    alc_pkg::alc_coef_t       coef;
    logic [2:0]               v_reg;
    logic [PW-1:0]            pos_reg, neg_reg;
    logic [16:0]              f1_reg;
    logic [PW-1:0]            diff_reg;
    logic                     neg1_reg;
    logic [16:0]              f2_reg;
    logic [VW-1:0]            val_reg;
    logic                     zero_reg;
    logic [VW-1:0]            rnd;

    // rounded ratio and segment lookup
    always_comb begin
        ratio = alc_pkg::RQ_W'(({1'b0, in_quo} + 12'd1) >> 1);
        coef  = alc_pkg::seg_lookup(in_item.kind, ratio);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (!stall) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    // stage 1: channel products; stage 2: difference; stage 3: calibration
    always_ff @(posedge aclk) begin
        if (!stall) begin
            pos_reg  <= PW'(in_item.ch0) * PW'(coef.b);
            neg_reg  <= PW'(in_item.ch1) * PW'(coef.m);
            f1_reg   <= in_item.factor;
            diff_reg <= pos_reg - neg_reg;
            neg1_reg <= pos_reg <= neg_reg;
            f2_reg   <= f1_reg;
            val_reg  <= VW'(diff_reg) * VW'(f2_reg);
            zero_reg <= neg1_reg;
        end
    end

    // rounding, clamp and saturation
    always_comb begin
        rnd = val_reg + VW'(32768);
        sat = 1'b0;
        lux = rnd[47:16];
        if (zero_reg) begin
            lux = '0;
        end else if (rnd[VW-1:48] != '0) begin
            lux = '1;
            sat = 1'b1;
        end
    end

    assign out_valid = v_reg[2];

    `ALC_ASSERT_IMP(a_sat_all_ones, aclk, aresetn, out_valid && sat, lux == 32'hffffffff,
        "saturated result is not all ones")
    `ALC_ASSERT_IMP(a_zero_no_sat, aclk, aresetn, out_valid && zero_reg, !sat && lux == '0,
        "negative difference not clamped")
    `ALC_ASSERT_NXT(a_hold, aclk, aresetn, stall, $stable(v_reg),
        "pipeline moved while stalled")
endmodule

// ===== hdl/ambient_light_lux_calculator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_light_lux_calculator_top
// Converts pairs of light-sensor counts into lux. Usage:
//  - s_ channel: tdata[15:0] broad_count, [31:16] infrared_count; one word
//    may be accepted every cycle while the row is not frozen.
//  - m_ channel: tdata[31:0] lux_value, tuser[0] lux_saturated.
//  - cfg channel: cfg_index selects calib_factor, gain_high, integ_time or
//    package_kind; write only while idle. Other indexes are ignored.
//  - pipeline: a scaling register, 11 division cells (one quotient bit each),
//    product, difference and calibration stages and the output register.
//  - throughput: one word per cycle unless stalled, set by the cell row.
//  - reset clears all valid flags and loads register reset values.
//  - when m_axis_tready is low with a word held, the whole row freezes
//    and s_axis_tready drops; the output register holds its word.
// ----------------------------------------------------------------------------
module ambient_light_lux_calculator_top #(
    parameter int ADC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // broad_count[15:0], infrared_count[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // lux_value[31:0]
    output logic [0:0]  m_axis_tuser,   // lux_saturated[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int NC = alc_pkg::NCELL;
    localparam int CW = alc_pkg::CH_W;

    logic [16:0] calib_reg;
    logic        gain_reg;
    logic [1:0]  integ_reg;
    logic        kind_reg;
    logic        stall;
    logic [15:0] scale;
    logic [20:0] sc;
    logic [15:0] raw0, raw1;
    logic        v0_reg;
    alc_pkg::alc_item_t item0_reg;
    alc_pkg::alc_div_t  div0;
    logic               cv [NC+1];
    alc_pkg::alc_item_t ci [NC+1];
    alc_pkg::alc_div_t  cd [NC+1];
    logic        lv;
    logic [31:0] lux;
    logic        sat;
    logic        ov_reg;
    logic [31:0] olux_reg;
    logic        osat_reg;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_reg <= 17'd1;
            gain_reg  <= 1'b0;
            integ_reg <= 2'd2;
            kind_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                alc_pkg::REG_CALIB:   calib_reg <= cfg_data[16:0];
                alc_pkg::REG_GAIN:    gain_reg  <= cfg_data[0];
                alc_pkg::REG_INTEG:   integ_reg <= cfg_data[1:0];
                alc_pkg::REG_PACKAGE: kind_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // freeze the row while a result word waits
    assign stall = ov_reg && !m_axis_tready;
    assign s_axis_tready = !stall;

    // integration-time and gain scale
    always_comb begin
        case (integ_reg)
            alc_pkg::INTEG_13MS:  scale = alc_pkg::SCALE_T0;
            alc_pkg::INTEG_101MS: scale = alc_pkg::SCALE_T1;
            default:              scale = alc_pkg::SCALE_NONE;
        endcase
        sc   = gain_reg ? {5'd0, scale} : {1'b0, scale, 4'd0};
        raw0 = 16'(s_axis_tdata[ADC_BITS-1:0]);
        raw1 = 16'(s_axis_tdata[16+ADC_BITS-1:16]);
    end

    // scaling stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (!stall) begin
            v0_reg <= s_axis_tvalid;
        end
    end
    always_ff @(posedge aclk) begin
        if (!stall) begin
            item0_reg.ch0    <= CW'((37'(raw0) * 37'(sc)) >> 10);
            item0_reg.ch1    <= CW'((37'(raw1) * 37'(sc)) >> 10);
            item0_reg.kind   <= kind_reg;
            item0_reg.factor <= calib_reg;
        end
    end

    // dividend ch1 << 10, quotient bits from msb down
    always_comb begin
        div0.rem = (CW+alc_pkg::RQ_W)'(item0_reg.ch1) << 10;
        div0.quo = '0;
    end
    assign cv[0] = v0_reg;
    assign ci[0] = item0_reg;
    assign cd[0] = div0;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        alc_div_cell #(.BIT(NC-1-g)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .stall(stall),
            .in_valid(cv[g]), .in_item(ci[g]), .in_div(cd[g]),
            .out_valid(cv[g+1]), .out_item(ci[g+1]), .out_div(cd[g+1])
        );
    end

    alc_lux_calc u_calc (
        .aclk(aclk), .aresetn(aresetn), .stall(stall),
        .in_valid(cv[NC]), .in_item(ci[NC]), .in_quo(cd[NC].quo),
        .out_valid(lv), .lux(lux), .sat(sat)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (!stall) begin
            ov_reg <= lv;
        end
    end
    always_ff @(posedge aclk) begin
        if (!stall) begin
            olux_reg <= lux;
            osat_reg <= sat;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = olux_reg;
    assign m_axis_tuser  = osat_reg;
endmodule

// ===== bench/lux_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lux_checker
// Watches the sample, result and register channels of the lux calculator,
// predicts each lux word from the sampled counts and the live register
// copies, and compares results in order.
// ----------------------------------------------------------------------------
module lux_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending_lux,
    output int          sat_seen,
    output int          zero_seen
);
    typedef struct packed {
        logic [31:0] lux;
        logic        sat;
    } lux_word_t;

    lux_word_t   lux_queue[$];
    logic [16:0] calib_q;
    logic        gain_q;
    logic [1:0]  integ_q;
    logic        pkg_q;

    // breakpoint tables: bound, b, m per segment
    function automatic void pick_segment(input logic kind, input logic [63:0] r,
                                         output logic [63:0] b, output logic [63:0] m);
        logic [63:0] bnd_t[5] = '{64'h0b3, 64'h100, 64'h133, 64'h171, 64'h1b3};
        logic [63:0] b_t[5]   = '{64'h1f4, 64'h217, 64'h1da, 64'h177, 64'h08d};
        logic [63:0] m_t[5]   = '{64'h2a4, 64'h30a, 64'h28f, 64'h1ec, 64'h0a6};
        logic [63:0] bnd_c[5] = '{64'h0b3, 64'h0e6, 64'h10a, 64'h157, 64'h1b3};
        logic [63:0] b_c[5]   = '{64'h1d3, 64'h214, 64'h265, 64'h102, 64'h0dd};
        logic [63:0] m_c[5]   = '{64'h27f, 64'h333, 64'h3e5, 64'h13c, 64'h104};
        b = 0;
        m = 0;
        for (int i = 4; i >= 0; i--) begin
            if (r <= (kind ? bnd_c[i] : bnd_t[i])) begin
                b = kind ? b_c[i] : b_t[i];
                m = kind ? m_c[i] : m_t[i];
            end
        end
    endfunction

    function automatic lux_word_t predict_lux(input logic [15:0] raw0, input logic [15:0] raw1);
        logic [63:0] scale, ch0, ch1, rq, b, m, pos, neg, v;
        lux_word_t w;
        if (integ_q == alc_pkg::INTEG_13MS) scale = 64'(alc_pkg::SCALE_T0);
        else if (integ_q == alc_pkg::INTEG_101MS) scale = 64'(alc_pkg::SCALE_T1);
        else scale = 64'h400;
        if (!gain_q) scale = scale << 4;
        ch0 = (64'(raw0) * scale) >> 10;
        ch1 = (64'(raw1) * scale) >> 10;
        rq = (ch0 != 0) ? (ch1 << 10) / ch0 : 0;
        rq = (rq + 1) >> 1;
        pick_segment(pkg_q, rq, b, m);
        pos = ch0 * b;
        neg = ch1 * m;
        w = '0;
        if (pos > neg) begin
            v = ((pos - neg) * 64'(calib_q) + 64'h8000) >> 16;
            if (v > 64'hffff_ffff) begin
                w.lux = 32'hffff_ffff;
                w.sat = 1'b1;
            end else begin
                w.lux = v[31:0];
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // track registers, predict on accepted samples, compare on results
    always @(posedge aclk) begin
        lux_word_t e;
        if (!aresetn) begin
            calib_q <= 17'd1;
            gain_q  <= 1'b0;
            integ_q <= 2'd2;
            pkg_q   <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                lux_queue.push_back(predict_lux(s_axis_tdata[15:0], s_axis_tdata[31:16]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (lux_queue.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    e = lux_queue.pop_front();
                    if (m_axis_tdata !== e.lux)
                        report_mismatch($sformatf("lux %h expected %h",
                                                  m_axis_tdata, e.lux));
                    if (m_axis_tuser[0] !== e.sat)
                        report_mismatch($sformatf("saturation %b expected %b",
                                                  m_axis_tuser[0], e.sat));
                    if (e.sat) sat_seen++;
                    if (e.lux == 0) zero_seen++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    alc_pkg::REG_CALIB:   calib_q <= cfg_data[16:0];
                    alc_pkg::REG_GAIN:    gain_q  <= cfg_data[0];
                    alc_pkg::REG_INTEG:   integ_q <= cfg_data[1:0];
                    alc_pkg::REG_PACKAGE: pkg_q   <= cfg_data[0];
                    default: ;
                endcase
            end
        end
        pending_lux = lux_queue.size();
    end

    initial begin
        fail_count = 0;
        sat_seen = 0;
        zero_seen = 0;
    end
endmodule

// ===== bench/ambient_light_lux_calculator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_light_lux_calculator_top_test
// Drives count pairs and register settings into the lux calculator, in part
// under random back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module ambient_light_lux_calculator_top_test;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int fail_count, pending_lux, sat_seen, zero_seen;
    int send_idle_pct, recv_idle_pct;
    int words_sent, idle_cycles;

    ambient_light_lux_calculator_top u_dut (.*);

    lux_checker u_check (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver back-pressure
    always @(negedge aclk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // valid stays high after a word so that words can follow back to back
    task automatic send_counts(input logic [15:0] c0, input logic [15:0] c1);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c1, c0};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    // caller drops cfg_valid after the last write of a group
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // wait until every expected word has come back, then for the pipeline
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_lux != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic apply_setting(input logic [16:0] f, input logic g,
                                 input logic [1:0] it, input logic k);
        drain();
        write_reg(alc_pkg::REG_CALIB, 32'({$urandom_range(32767), 17'd0}) | 32'(f));
        write_reg(alc_pkg::REG_GAIN, 32'({$urandom, 1'b0}) | 32'(g));
        write_reg(alc_pkg::REG_INTEG, 32'({$urandom, 2'b0}) | 32'(it));
        write_reg(alc_pkg::REG_PACKAGE, 32'({$urandom, 1'b0}) | 32'(k));
        cfg_valid <= 1'b0;
    endtask

    // counts with a chosen ratio band, or raw random ones
    task automatic send_random;
        logic [15:0] c0, c1;
        case ($urandom_range(4))
            0: begin
                c0 = 16'($urandom);
                c1 = 16'($urandom);
            end
            1: begin
                c0 = 16'($urandom_range(255));
                c1 = 16'($urandom_range(255));
            end
            default: begin
                c0 = 16'($urandom);
                c1 = 16'((32'(c0) * $urandom_range(480)) >> 9);
            end
        endcase
        send_counts(c0, c1);
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        words_sent = 0;
        idle_cycles = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset settings, field extremes and the special cases
        send_counts(16'd0, 16'd0);
        send_counts(16'd0, 16'hffff);
        send_counts(16'hffff, 16'd0);
        send_counts(16'hffff, 16'hffff);
        send_counts(16'd1000, 16'd1000);
        send_counts(16'd1000, 16'd100);
        send_counts(16'd1000, 16'd500);
        apply_setting(17'h1ffff, 1'b0, 2'd3, 1'b0);
        send_counts(16'hffff, 16'd0);
        send_counts(16'hffff, 16'h1000);
        send_counts(16'h8000, 16'h5555);
        apply_setting(17'h10000, 1'b1, 2'd0, 1'b1);
        send_counts(16'hffff, 16'h2000);
        send_counts(16'd300, 16'd150);
        send_counts(16'd1, 16'd1);
        apply_setting(17'd0, 1'b1, 2'd1, 1'b1);
        send_counts(16'hffff, 16'h1234);
        drain();
        write_reg(alc_pkg::REG_PACKAGE, 32'h0);
        cfg_valid <= 1'b0;
        send_counts(16'd500, 16'd100);

        // random phases of pressure, with settings swapped between blocks
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 66 : 0;
            recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 15 : 0;
            for (int blk = 0; blk < 8; blk++) begin
                case ($urandom_range(3))
                    0: apply_setting(17'h1ffff, 1'($urandom), 2'($urandom),
                                     1'($urandom));
                    1: apply_setting(17'd0, 1'($urandom), 2'($urandom), 1'($urandom));
                    default: apply_setting(17'($urandom_range(17'h1ffff)), 1'($urandom),
                                           2'($urandom), 1'($urandom));
                endcase
                repeat (66) send_random();
            end
        end

        drain();
        $display("sent %0d count pairs over several register settings", words_sent);
        $display("saturated results %0d, zero results %0d", sat_seen, zero_seen);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
